FILE: rtl/lz10sd_pkg.sv
// Package: shared types and constants for the LZ10 stream decompressor.
`timescale 1ns / 1ps

package lz10sd_pkg;

  localparam int HISTORY_DEPTH = 8192;

  localparam int BYTE_W      = 8;
  localparam int SIZE_W      = 24;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_OVERLAY_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_SIZE  = 2'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EARLY_END = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_DIST = 2'd2;

  // Reference token decoding
  localparam int          COUNT_SHIFT       = 12;
  localparam logic [11:0] DIST_MASK         = 12'hfff;
  localparam logic [4:0]  COUNT_BIAS        = 5'd3;
  localparam logic [12:0] DIST_BIAS_NORMAL  = 13'd1;
  localparam logic [12:0] DIST_BIAS_OVERLAY = 13'd3;
  localparam int          DIST_W            = 13;
  localparam int          COUNT_W           = 5;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                out_last;
    logic [STATUS_W-1:0] status;
  } out_item_t;

endpackage

FILE: rtl/lz10sd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lz10sd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lz10_stream_decompressor.sv
// LZ10 (LZSS) stream decompressor: sequencer, history window and output register.
`timescale 1ns / 1ps

// Takes the compressed stream (header already stripped) one byte per input beat and
// emits the decompressed bytes one per output beat, marking the byte that reaches
// output_size with out_last. A flag byte or the high byte of a reference is accepted
// and then decoded; a literal is also written to the history and emitted. The low
// byte of a reference is decoded, then the copy is set up, and every copied byte is
// a read of the history RAM followed by its write. The block is not ready for input
// while a token is being worked on, and stalls when the output register is held.
// Input ending early reports status 1 and a distance before the start of the output
// reports status 2, each on a beat with out_last set; after that, and after a byte
// reaches output_size, all input is dropped until reset. Input is also dropped while
// output_size is not above the bytes produced. The history window needs no clearing
// after reset. Configuration is taken at any time but must only change while idle.
module lz10_stream_decompressor #(
  parameter int HISTORY_DEPTH = lz10sd_pkg::HISTORY_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  lz10sd_pkg::in_item_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output lz10sd_pkg::out_item_t                 out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lz10sd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lz10sd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_SETUP   = 3'd2;
  localparam logic [2:0] S_COPY_RD = 3'd3;
  localparam logic [2:0] S_COPY_WR = 3'd4;
  localparam logic [2:0] S_ERR     = 3'd5;

  localparam logic [1:0] PH_FLAGS = 2'd0;
  localparam logic [1:0] PH_TOKEN = 2'd1;
  localparam logic [1:0] PH_REF_LO = 2'd2;

  localparam logic [AW-1:0] PTR_LAST = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);

  logic [2:0] state;

  logic                                overlay_mode;
  logic [lz10sd_pkg::SIZE_W-1:0]       output_size;

  logic [7:0]                          flag_bits;
  logic [3:0]                          flags_left;
  logic [1:0]                          token_phase;
  logic [7:0]                          reference_high;
  logic [lz10sd_pkg::SIZE_W-1:0]       produced_count;
  logic                                finished;

  logic [7:0]                          cur_byte;
  logic                                cur_last;
  logic [lz10sd_pkg::DIST_W-1:0]       ref_dist;
  logic [lz10sd_pkg::COUNT_W-1:0]      remaining;
  logic [AW-1:0]                       wr_ptr;
  logic [AW-1:0]                       src_ptr;
  logic [lz10sd_pkg::STATUS_W-1:0]     err_status;

  logic                                ram_we;
  logic [7:0]                          ram_wdata;
  logic [7:0]                          ram_rdata;

  logic                                out_free;
  logic                                out_load;
  logic                                active;
  logic [lz10sd_pkg::SIZE_W-1:0]       produced_plus;
  logic                                size_hit;
  logic                                lit_fire;
  logic [3:0]                          flags_left_dec;
  logic [AW:0]                         src_diff;
  logic                                copy_final;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_free      = !out_valid || out_ready;
  assign active        = !finished && (produced_count < output_size);
  assign produced_plus = produced_count + 24'd1;
  assign size_hit      = (produced_plus == output_size);
  assign lit_fire      = (state == S_DECODE) && active && (token_phase == PH_TOKEN) &&
                         !flag_bits[7] && out_free;
  assign out_load      = lit_fire || (state == S_COPY_WR) || ((state == S_ERR) && out_free);
  assign flags_left_dec = (flags_left != 4'd0) ? flags_left - 4'd1 : 4'd0;
  assign src_diff      = {1'b0, wr_ptr} - (AW+1)'(ref_dist);
  assign copy_final    = (remaining == 5'd1) || size_hit;

  assign ram_we    = lit_fire || (state == S_COPY_WR);
  assign ram_wdata = (state == S_COPY_WR) ? ram_rdata : cur_byte;

  lz10sd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (ram_wdata),
    .raddr (src_ptr),
    .rdata (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      overlay_mode <= 1'b0;
      output_size  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lz10sd_pkg::REG_OVERLAY_MODE: overlay_mode <= cfg_data[0];
        lz10sd_pkg::REG_OUTPUT_SIZE:  output_size  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_byte <= in_data.in_byte;
      cur_last <= in_data.in_last;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      flag_bits      <= '0;
      flags_left     <= '0;
      token_phase    <= PH_FLAGS;
      reference_high <= '0;
      produced_count <= '0;
      finished       <= 1'b0;
      wr_ptr         <= '0;
      src_ptr        <= '0;
      remaining      <= '0;
      ref_dist       <= '0;
      err_status     <= lz10sd_pkg::STATUS_OK;
      out_valid      <= 1'b0;
      out_data       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end

        S_DECODE: begin
          if (!active) begin
            state <= S_IDLE;
          end else begin
            unique case (token_phase)
              PH_FLAGS: begin
                flag_bits   <= cur_byte;
                flags_left  <= 4'd8;
                token_phase <= PH_TOKEN;
                err_status  <= lz10sd_pkg::STATUS_EARLY_END;
                state       <= cur_last ? S_ERR : S_IDLE;
              end
              PH_TOKEN: begin
                if (flag_bits[7]) begin
                  reference_high <= cur_byte;
                  token_phase    <= PH_REF_LO;
                  err_status     <= lz10sd_pkg::STATUS_EARLY_END;
                  state          <= cur_last ? S_ERR : S_IDLE;
                end else if (out_free) begin
                  // literal: write history, emit, close the token
                  out_data.out_byte <= cur_byte;
                  out_data.out_last <= size_hit || cur_last;
                  out_data.status   <= (!size_hit && cur_last) ?
                                       lz10sd_pkg::STATUS_EARLY_END : lz10sd_pkg::STATUS_OK;
                  produced_count    <= produced_plus;
                  wr_ptr            <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + AW'(1);
                  flag_bits         <= {flag_bits[6:0], 1'b0};
                  flags_left        <= flags_left_dec;
                  token_phase       <= (flags_left_dec != 4'd0) ? PH_TOKEN : PH_FLAGS;
                  finished          <= size_hit || cur_last;
                  state             <= S_IDLE;
                end
              end
              PH_REF_LO: begin
                ref_dist <= {1'b0, reference_high[3:0], cur_byte} +
                            (overlay_mode ? lz10sd_pkg::DIST_BIAS_OVERLAY
                                          : lz10sd_pkg::DIST_BIAS_NORMAL);
                remaining <= {1'b0, reference_high[7:4]} + lz10sd_pkg::COUNT_BIAS;
                state     <= S_SETUP;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_SETUP: begin
          if (lz10sd_pkg::SIZE_W'(ref_dist) > produced_count) begin
            err_status <= lz10sd_pkg::STATUS_BAD_DIST;
            state      <= S_ERR;
          end else begin
            // wrap the source pointer back into the window
            src_ptr <= src_diff[AW] ? AW'(src_diff + DEPTH_EXT) : src_diff[AW-1:0];
            state   <= S_COPY_RD;
          end
        end

        S_COPY_RD: begin
          if (out_free) begin
            state <= S_COPY_WR;
          end
        end

        S_COPY_WR: begin
          out_data.out_byte <= ram_rdata;
          out_data.out_last <= size_hit || (copy_final && cur_last);
          out_data.status   <= (!size_hit && copy_final && cur_last) ?
                               lz10sd_pkg::STATUS_EARLY_END : lz10sd_pkg::STATUS_OK;
          produced_count    <= produced_plus;
          wr_ptr            <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + AW'(1);
          src_ptr           <= (src_ptr == PTR_LAST) ? '0 : src_ptr + AW'(1);
          remaining         <= remaining - 5'd1;
          if (copy_final) begin
            flag_bits   <= {flag_bits[6:0], 1'b0};
            flags_left  <= flags_left_dec;
            token_phase <= (flags_left_dec != 4'd0) ? PH_TOKEN : PH_FLAGS;
            finished    <= size_hit || cur_last;
            state       <= S_IDLE;
          end else begin
            state <= S_COPY_RD;
          end
        end

        S_ERR: begin
          if (out_free) begin
            out_data.out_byte <= '0;
            out_data.out_last <= 1'b1;
            out_data.status   <= err_status;
            finished          <= 1'b1;
            state             <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/lz10_stream_decompressor_checker.sv
// Checker for the LZ10 stream decompressor: decodes accepted input beats and compares output.
`timescale 1ns / 1ps

module lz10_stream_decompressor_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  lz10sd_pkg::in_item_t               in_data,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  lz10sd_pkg::out_item_t              out_data,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [lz10sd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lz10sd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                 fail_count,
  output int                                 backlog
);

  typedef enum logic [1:0] {WANT_FLAGS, WANT_TOKEN, WANT_REF_LOW} token_phase_t;

  localparam int MAX_RUN = 18;

  logic                          overlay_mode;
  logic [lz10sd_pkg::SIZE_W-1:0] output_size;

  logic [7:0]                    flag_bits;
  int                            flags_left;
  token_phase_t                  phase;
  logic [7:0]                    ref_high;
  logic [lz10sd_pkg::SIZE_W-1:0] produced;
  logic                          finished;
  logic [lz10sd_pkg::BYTE_W-1:0] window [lz10sd_pkg::HISTORY_DEPTH];

  lz10sd_pkg::out_item_t decoded_q[$];

  function automatic lz10sd_pkg::out_item_t store_byte(input logic [lz10sd_pkg::BYTE_W-1:0] b);
    window[int'(produced) % lz10sd_pkg::HISTORY_DEPTH] = b;
    produced = produced + 1'b1;
    return '{out_byte: b, out_last: 1'b0, status: lz10sd_pkg::STATUS_OK};
  endfunction

  function automatic void next_token();
    flag_bits = flag_bits << 1;
    if (flags_left > 0) flags_left--;
    phase = (flags_left != 0) ? WANT_TOKEN : WANT_FLAGS;
  endfunction

  task automatic decode_beat(input lz10sd_pkg::in_item_t beat);
    lz10sd_pkg::out_item_t run [MAX_RUN];
    int          n;
    int          i;
    int          run_len;
    int          span;
    logic [15:0] pair;
    n = 0;
    // drop everything once done, or while the size is already met
    if (finished || produced >= output_size) return;
    case (phase)
      WANT_FLAGS: begin
        flag_bits  = beat.in_byte;
        flags_left = 8;
        phase      = WANT_TOKEN;
      end
      WANT_TOKEN: begin
        if (!flag_bits[7]) begin
          run[n] = store_byte(beat.in_byte);
          n++;
          next_token();
        end else begin
          ref_high = beat.in_byte;
          phase    = WANT_REF_LOW;
        end
      end
      default: begin
        pair    = {ref_high, beat.in_byte};
        run_len = int'(pair[15:lz10sd_pkg::COUNT_SHIFT]) + int'(lz10sd_pkg::COUNT_BIAS);
        span    = int'(pair[11:0] & lz10sd_pkg::DIST_MASK)
                  + int'(overlay_mode ? lz10sd_pkg::DIST_BIAS_OVERLAY
                                      : lz10sd_pkg::DIST_BIAS_NORMAL);
        if (span > int'(produced)) begin
          run[0] = '{out_byte: '0, out_last: 1'b1, status: lz10sd_pkg::STATUS_BAD_DIST};
          decoded_q.insert(decoded_q.size(), run[0]);
          finished = 1'b1;
          return;
        end
        for (i = 0; i < run_len && produced < output_size; i++) begin
          run[n] = store_byte(window[(int'(produced) - span) % lz10sd_pkg::HISTORY_DEPTH]);
          n++;
        end
        next_token();
      end
    endcase

    if (produced >= output_size) begin
      if (n > 0) run[n-1].out_last = 1'b1;
      finished = 1'b1;
    end else if (beat.in_last) begin
      if (n > 0) begin
        run[n-1].out_last = 1'b1;
        run[n-1].status   = lz10sd_pkg::STATUS_EARLY_END;
      end else begin
        run[0] = '{out_byte: '0, out_last: 1'b1, status: lz10sd_pkg::STATUS_EARLY_END};
        n = 1;
      end
      finished = 1'b1;
    end
    for (i = 0; i < n; i++) decoded_q.insert(decoded_q.size(), run[i]);
  endtask

  always @(posedge clk) begin
    lz10sd_pkg::out_item_t want;
    if (rst) begin
      overlay_mode = 1'b0;
      output_size  = '0;
      flag_bits    = '0;
      flags_left   = 0;
      phase        = WANT_FLAGS;
      ref_high     = '0;
      produced     = '0;
      finished     = 1'b0;
      fail_count   = 0;
      decoded_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lz10sd_pkg::REG_OVERLAY_MODE: overlay_mode = cfg_data[0];
          lz10sd_pkg::REG_OUTPUT_SIZE:  output_size  = cfg_data[lz10sd_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) decode_beat(in_data);
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected output beat: out_byte %02h out_last %0d status %0d",
                 out_data.out_byte, out_data.out_last, out_data.status);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
            fail_count++;
          end
          if (out_data.out_last !== want.out_last) begin
            $error("out_last: expected %0d, got %0d", want.out_last, out_data.out_last);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
        end
      end
    end
    backlog = decoded_q.size();
  end

endmodule

FILE: tb/lz10_stream_decompressor_tb.sv
// Top of the LZ10 stream decompressor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module lz10_stream_decompressor_tb;

  typedef enum int {END_SIZE_REACHED, END_EARLY_WITH_DATA, END_EARLY_NO_DATA,
                    END_BAD_DISTANCE} ending_t;

  localparam logic [lz10sd_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [lz10sd_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int MAX_DIST_CODE   = 4095;
  localparam int SETTLE_CYCLES   = 12;
  localparam int DRAIN_CYCLES    = 60;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_ready;
  lz10sd_pkg::in_item_t               in_data;
  logic                               out_valid;
  logic                               out_ready;
  lz10sd_pkg::out_item_t              out_data;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [lz10sd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lz10sd_pkg::CFG_DATA_W-1:0]  cfg_data;

  int   fail_count;
  int   backlog;
  int   quiet_cycles = 0;

  // stream bookkeeping on the sending side, kept to stay within the window
  int   made        = 0;
  int   items_sent  = 0;
  int   burst_left  = 1;
  logic offering    = 1'b0;
  logic overlay_now = 1'b0;
  logic squeeze_req = 1'b0;

  lz10_stream_decompressor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lz10_stream_decompressor_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: spans of a repeating ready mask, plus one long hold-off on request
  initial begin : receiver
    int         span;
    int         k;
    logic [7:0] mask;
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        span = $urandom_range(8, 64);
        mask = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom());
        for (k = 0; k < span; k++) begin
          out_ready <= mask[k % 8];
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lz10_stream_decompressor_tb failed");
      $finish;
    end
  end

  function automatic int dist_bias();
    return overlay_now ? int'(lz10sd_pkg::DIST_BIAS_OVERLAY)
                       : int'(lz10sd_pkg::DIST_BIAS_NORMAL);
  endfunction

  task automatic send_beat(input logic [lz10sd_pkg::BYTE_W-1:0] b, input logic last);
    int gap;
    in_data  <= '{in_byte: b, in_last: last};
    in_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_ref(input int nib, input int distance, input logic last);
    logic [11:0] code;
    code = 12'(distance - dist_bias());
    send_beat({4'(nib), code[11:8]}, 1'b0);
    send_beat(code[7:0], last);
    made += nib + int'(lz10sd_pkg::COUNT_BIAS);
  endtask

  // one flag byte and its eight tokens, references weighted toward long copies
  task automatic send_random_group();
    logic [7:0] flags;
    int         k;
    int         far;
    int         distance;
    flags = 8'($urandom() | $urandom());
    send_beat(flags, 1'b0);
    for (k = 7; k >= 0; k--) begin
      if (!flags[k]) begin
        send_beat(8'($urandom()), 1'b0);
        made++;
      end else begin
        far = (made < MAX_DIST_CODE + dist_bias()) ? made : MAX_DIST_CODE + dist_bias();
        case ($urandom_range(0, 3))
          0: distance = $urandom_range(dist_bias(),
                                       (far < dist_bias() + 3) ? far : dist_bias() + 3);
          1: distance = far;
          default: distance = $urandom_range(dist_bias(), far);
        endcase
        send_ref($urandom_range(0, 1) ? 15 : $urandom_range(0, 15), distance, 1'b0);
      end
    end
  endtask

  task automatic send_noise(input int count);
    int k;
    for (k = 0; k < count; k++) send_beat(8'($urandom()), 1'($urandom()));
  endtask

  task automatic write_reg(input logic [lz10sd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lz10sd_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // wait out every pending output, then let a trailing flag or high byte finish
  task automatic settle();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    ending_t    ending;
    int         target;
    int         k;
    logic [7:0] corner_bytes [8];
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // output size is zero out of reset: every beat is dropped
    send_noise(6);
    settle();

    // overlay bit is masked from a wide write, spare indexes are ignored
    write_reg(lz10sd_pkg::REG_OVERLAY_MODE, 24'hfffffe);
    overlay_now = 1'b0;
    write_reg(lz10sd_pkg::REG_OUTPUT_SIZE, 24'hffffff);
    write_reg(REG_SPARE_A, 24'($urandom()));
    write_reg(REG_SPARE_B, 24'hffffff);
    cfg_valid <= 1'b0;

    corner_bytes = '{8'h00, 8'hff, 8'ha5, 8'h5a, 8'h80, 8'h01, 8'h7f, 8'hfe};
    send_beat(8'h00, 1'b0);
    for (k = 0; k < 8; k++) begin
      send_beat(corner_bytes[k], 1'b0);
      made++;
    end
    // self-overlapping copies, longest copies, distance equal to the output so far
    send_beat(8'hff, 1'b0);
    send_ref(0, 1, 1'b0);
    send_ref(15, 1, 1'b0);
    send_ref(15, made, 1'b0);
    send_ref(7, 3, 1'b0);
    send_ref(0, made, 1'b0);
    send_ref(15, 2, 1'b0);
    send_ref(4, 17, 1'b0);
    send_ref(15, made, 1'b0);
    settle();

    write_reg(lz10sd_pkg::REG_OVERLAY_MODE, 24'h000001);
    overlay_now = 1'b1;
    cfg_valid <= 1'b0;
    squeeze_req = 1'b1;
    target = items_sent + 200;
    while (items_sent < target) send_random_group();
    settle();

    // lower the size to what is already out: beats are dropped, state holds
    write_reg(lz10sd_pkg::REG_OUTPUT_SIZE, 24'(made));
    cfg_valid <= 1'b0;
    send_noise(6);
    settle();

    write_reg(lz10sd_pkg::REG_OVERLAY_MODE, 24'h000000);
    overlay_now = 1'b0;
    write_reg(lz10sd_pkg::REG_OUTPUT_SIZE, 24'hffffff);
    cfg_valid <= 1'b0;
    target = items_sent + 220;
    while (items_sent < target) send_random_group();
    settle();

    // only one terminating case fits in a run, the seed picks which
    ending = ending_t'($urandom_range(0, 3));
    if (ending == END_BAD_DISTANCE && made + 1 - dist_bias() > MAX_DIST_CODE)
      ending = END_EARLY_NO_DATA;
    case (ending)
      END_SIZE_REACHED: begin
        write_reg(lz10sd_pkg::REG_OUTPUT_SIZE, 24'(made + $urandom_range(1, 17)));
        cfg_valid <= 1'b0;
        send_beat(8'hff, 1'b0);
        send_ref(15, 1, 1'b1);
      end
      END_EARLY_WITH_DATA: begin
        send_beat(8'h00, 1'b0);
        send_beat(8'($urandom()), 1'b1);
      end
      END_EARLY_NO_DATA: send_beat(8'($urandom()), 1'b1);
      default: begin
        send_beat(8'hff, 1'b0);
        send_ref($urandom_range(0, 15), made + 1, 1'b0);
      end
    endcase
    // after the stream has ended everything is dropped
    send_noise(5);
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && backlog == 0)
      $display("lz10_stream_decompressor_tb passed");
    else
      $display("lz10_stream_decompressor_tb failed");
    $finish;
  end

endmodule
